// ----- rtl/core/plm_pkg.sv -----
// ----------------------------------------------------------------------------
// plm_pkg
// shared types and constants of the pcm level meter
// ----------------------------------------------------------------------------
package plm_pkg;

  // command codes carried in the func field
  localparam logic FUNC_SAMPLE   = 1'b0;
  localparam logic FUNC_SNAPSHOT = 1'b1;

  // conversion: divide by 256 with truncation toward zero
  localparam int unsigned DIV_SHIFT = 8;
  localparam logic [31:0] ROUND_BIAS = 32'd255;

  localparam int unsigned RAW_W  = 32;
  localparam int unsigned PCM_W  = 16;
  localparam int unsigned QUOT_W = RAW_W - DIV_SHIFT;
  localparam int unsigned MAG_W  = PCM_W + 1;

  localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7fff;
  localparam logic signed [PCM_W-1:0] PCM_MIN = -16'sh8000;

  typedef struct packed {
    logic              func;
    logic signed [31:0] raw_sample;
    logic              block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               sample_valid;
    logic signed [15:0] snap_min;
    logic signed [15:0] snap_max;
    logic [31:0]        snap_sum_abs;
    logic [31:0]        snap_count;
    logic [31:0]        snap_blocks;
  } out_item_t;

  // converted sample and its magnitude
  typedef struct packed {
    logic signed [PCM_W-1:0] pcm;
    logic [MAG_W-1:0]        mag;
  } conv_t;

endpackage

// ----- rtl/core/plm_if.sv -----
// ----------------------------------------------------------------------------
// plm_if
// valid/ready channels of the pcm level meter
// ----------------------------------------------------------------------------
interface plm_in_if import plm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface plm_out_if import plm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/plm_convert.sv -----
// ----------------------------------------------------------------------------
// plm_convert
// scales a filter word to 16-bit pcm with saturation, and its magnitude
// ----------------------------------------------------------------------------
module plm_convert import plm_pkg::*; (
  input  logic signed [RAW_W-1:0] raw_sample,
  output conv_t                   conv
);

  logic [RAW_W-1:0]         biased;
  logic signed [QUOT_W-1:0] quot;
  logic signed [PCM_W-1:0]  pcm;
  logic [MAG_W-1:0]         ext;

  // bias negatives so the arithmetic shift truncates toward zero
  assign biased = raw_sample[RAW_W-1] ? (raw_sample + ROUND_BIAS) : raw_sample;
  assign quot   = $signed(biased[RAW_W-1:DIV_SHIFT]);

  always_comb begin
    if (quot > QUOT_W'(PCM_MAX)) begin
      pcm = PCM_MAX;
    end else if (quot < QUOT_W'(PCM_MIN)) begin
      pcm = PCM_MIN;
    end else begin
      pcm = quot[PCM_W-1:0];
    end
  end

  // magnitude needs one extra bit for -32768
  assign ext       = {pcm[PCM_W-1], pcm};
  assign conv.pcm  = pcm;
  assign conv.mag  = pcm[PCM_W-1] ? (~ext + MAG_W'(1)) : ext;

endmodule

// ----- rtl/core/pcm_level_meter.sv -----
// ----------------------------------------------------------------------------
// pcm_level_meter
// microphone level meter: pcm conversion plus min/max/sum-abs statistics
// ----------------------------------------------------------------------------
// usage
//   samples : input beats {func, raw_sample, block_end}. func = sample
//             converts raw_sample (divide by 256 toward zero, saturate to
//             16 bits) and folds it into the running statistics; func =
//             snapshot reports min, max, sum of magnitudes, sample count
//             and block count, then clears them. block_end counts a block
//             on a sample beat only.
//   results : exactly one output beat per input beat, in order.
// timing
//   two register stages: an input register and the result register. an
//   accepted beat loads the input register, then moves into the result
//   register once that register is free or draining, which raises
//   results.valid. one beat per cycle sustained while results is ready;
//   the only loop is the statistics update, which is a single
//   compare/add per cycle between the input and result registers.
// reset
//   synchronous rst empties both stages and sets min to 32767, max to
//   -32768 and all counters to zero.
// stall
//   while results is stalled the result register holds; the input register
//   still takes one more beat, after which samples.ready drops.
// ----------------------------------------------------------------------------
module pcm_level_meter import plm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  plm_in_if.sink     samples,
  plm_out_if.source  results
);

  // input stage
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_fire;

  // result stage
  logic      out_valid;
  out_item_t out_item;
  out_item_t out_item_next;

  // running statistics
  logic signed [PCM_W-1:0] run_min;
  logic signed [PCM_W-1:0] run_max;
  logic [31:0]             abs_total;
  logic [31:0]             sample_tally;
  logic [31:0]             block_tally;

  conv_t conv;

  // the input stage moves on whenever the result register is free or drains
  assign s1_fire       = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_item <= samples.data;
    end
  end

  plm_convert u_convert (
    .raw_sample (s1_item.raw_sample),
    .conv       (conv)
  );

  // result beat: statistics fields are zero on a sample, pcm zero on a snapshot
  always_comb begin
    out_item_next = '0;
    if (s1_item.func == FUNC_SNAPSHOT) begin
      out_item_next.snap_min     = run_min;
      out_item_next.snap_max     = run_max;
      out_item_next.snap_sum_abs = abs_total;
      out_item_next.snap_count   = sample_tally;
      out_item_next.snap_blocks  = block_tally;
    end else begin
      out_item_next.pcm_sample   = conv.pcm;
      out_item_next.sample_valid = 1'b1;
    end
  end

  // statistics advance together with the input stage, so order is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      run_min      <= PCM_MAX;
      run_max      <= PCM_MIN;
      abs_total    <= '0;
      sample_tally <= '0;
      block_tally  <= '0;
    end else if (s1_fire) begin
      if (s1_item.func == FUNC_SNAPSHOT) begin
        run_min      <= PCM_MAX;
        run_max      <= PCM_MIN;
        abs_total    <= '0;
        sample_tally <= '0;
        block_tally  <= '0;
      end else begin
        if (conv.pcm < run_min) begin
          run_min <= conv.pcm;
        end
        if (conv.pcm > run_max) begin
          run_max <= conv.pcm;
        end
        abs_total    <= abs_total + {{(32-MAG_W){1'b0}}, conv.mag};
        sample_tally <= sample_tally + 32'd1;
        if (s1_item.block_end) begin
          block_tally <= block_tally + 32'd1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item <= out_item_next;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_item;

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------

  // a snapshot leaves the statistics at their cleared values
  a_snap_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && (s1_item.func == FUNC_SNAPSHOT) |=>
      (run_min == PCM_MAX) && (run_max == PCM_MIN) && (sample_tally == 32'd0)
      && (abs_total == 32'd0) && (block_tally == 32'd0))
    else $error("statistics not cleared after snapshot");

  // every processed sample counts once
  a_sample_counts: assert property (@(posedge clk) disable iff (rst)
    s1_fire && (s1_item.func == FUNC_SAMPLE) |=>
      sample_tally == $past(sample_tally) + 32'd1)
    else $error("sample count did not advance");

  // a beat in the input stage is never dropped while results stall
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_item))
    else $error("input stage lost a beat under stall");

  // min never exceeds max once a sample has been seen
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    sample_tally != 32'd0 && $past(s1_fire) |-> run_min <= run_max)
    else $error("running min above running max");

endmodule
